>>> rtl/core/u2c_pkg.sv
// u2c_pkg: shared types, constants and the code point to Windows-1252 map
// for the UTF-8 to CP1252 transcoder. No dependencies.
`timescale 1ns / 1ps

package u2c_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_text;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_out;
	} out_t;

	typedef struct packed {
		logic [20:0] code_accum;
		logic [1:0]  bytes_pending;
	} st_t;

	typedef struct packed {
		logic [1:0]      cnt;
		out_t [1:0]      res;
	} dec_t;

	localparam logic [31:0] LANG_RESET      = 32'h0001_0000;
	localparam logic [31:0] LANG_UPPER_MASK = 32'hffff_0000;
	localparam logic [31:0] POLISH_SELECT   = 32'h0011_0000;
	localparam logic [7:0]  SPACE_BYTE      = 8'h20;
	localparam logic [7:0]  APOS_BYTE       = 8'h27;
	localparam logic [7:0]  QUOTE_BYTE      = 8'h22;
	localparam logic [7:0]  CONT_MASK       = 8'hc0;
	localparam logic [7:0]  CONT_MARK       = 8'h80;
	localparam logic [7:0]  LEAD2_MASK      = 8'he0;
	localparam logic [7:0]  LEAD2_MARK      = 8'hc0;
	localparam logic [7:0]  LEAD3_MASK      = 8'hf0;
	localparam logic [7:0]  LEAD3_MARK      = 8'he0;
	localparam logic [7:0]  LEAD4_MASK      = 8'hf8;
	localparam logic [7:0]  LEAD4_MARK      = 8'hf0;
	localparam int          RES_DEPTH       = 4;

	localparam logic [15:0] HIGH_TABLE [32] = '{
		16'h20ac, 16'h0000, 16'h201a, 16'h0192, 16'h201e, 16'h2026, 16'h2020, 16'h2021,
		16'h02c6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017d, 16'h0000,
		16'h0000, 16'h2018, 16'h2019, 16'h201c, 16'h201d, 16'h2022, 16'h2013, 16'h2014,
		16'h02dc, 16'h2122, 16'h0161, 16'h203a, 16'h0153, 16'h0000, 16'h017e, 16'h0178
	};

	function automatic logic [7:0] map_code(input logic [20:0] cp);
		logic [7:0] r;
		r = SPACE_BYTE;
		if (cp == 21'h2018 || cp == 21'h2019) begin
			r = APOS_BYTE;
		end else if (cp == 21'h201c || cp == 21'h201d) begin
			r = QUOTE_BYTE;
		end else if (cp == 21'h00a0) begin
			r = SPACE_BYTE;
		end else if (cp < 21'h80 || (cp >= 21'ha0 && cp <= 21'hff)) begin
			r = cp[7:0];
		end else begin
			for (int i = 0; i < 32; i++) begin
				if (HIGH_TABLE[i] != 16'h0000 && {5'b0, HIGH_TABLE[i]} == cp) begin
					r = CONT_MARK | 8'(i);
				end
			end
		end
		return r;
	endfunction

endpackage

>>> rtl/core/u2c_decode.sv
// u2c_decode: one-byte UTF-8 decode step (or raw pass-through), gives next state and up to two results.
// Depends on u2c_pkg.
`timescale 1ns / 1ps

module u2c_decode (
	input  logic [7:0]   in_byte,
	input  logic         end_of_text,
	input  logic         pass_thru,
	input  u2c_pkg::st_t st,
	output u2c_pkg::st_t nst,
	output u2c_pkg::dec_t dec
);

	typedef struct packed {
		logic         emit;
		logic [7:0]   byt;
		u2c_pkg::st_t st;
	} fresh_t;

	function automatic fresh_t fresh(input logic [7:0] b);
		fresh_t f;
		f = '0;
		if (b[7] == 1'b0) begin
			f.emit = 1'b1;
			f.byt  = b;
		end else if ((b & u2c_pkg::LEAD2_MASK) == u2c_pkg::LEAD2_MARK) begin
			f.st.code_accum    = {16'b0, b[4:0]};
			f.st.bytes_pending = 2'd1;
		end else if ((b & u2c_pkg::LEAD3_MASK) == u2c_pkg::LEAD3_MARK) begin
			f.st.code_accum    = {17'b0, b[3:0]};
			f.st.bytes_pending = 2'd2;
		end else if ((b & u2c_pkg::LEAD4_MASK) == u2c_pkg::LEAD4_MARK) begin
			f.st.code_accum    = {18'b0, b[2:0]};
			f.st.bytes_pending = 2'd3;
		end else begin
			f.emit = 1'b1;
			f.byt  = u2c_pkg::SPACE_BYTE;
		end
		return f;
	endfunction

	fresh_t      fr;
	logic [20:0] acc_next;
	logic [1:0]  n;

	always_comb begin
		fr       = fresh(in_byte);
		acc_next = {st.code_accum[14:0], in_byte[5:0]};
		nst      = st;
		n        = 2'd0;
		dec      = '0;
		if (pass_thru) begin
			nst = '0;
			dec.res[0].out_byte = in_byte;
			n = 2'd1;
		end else if (st.bytes_pending != 2'd0 &&
				(in_byte & u2c_pkg::CONT_MASK) == u2c_pkg::CONT_MARK) begin
			nst.code_accum    = acc_next;
			nst.bytes_pending = st.bytes_pending - 2'd1;
			if (st.bytes_pending == 2'd1) begin
				nst.code_accum = '0;
				dec.res[0].out_byte = u2c_pkg::map_code(acc_next);
				n = 2'd1;
			end
		end else begin
			if (st.bytes_pending != 2'd0) begin
				// broken sequence: space, then decode this byte afresh
				dec.res[0].out_byte = u2c_pkg::SPACE_BYTE;
				n = 2'd1;
			end
			nst = fr.st;
			if (fr.emit) begin
				dec.res[n[0]].out_byte = fr.byt;
				n = n + 2'd1;
			end
		end
		if (end_of_text) begin
			if (nst.bytes_pending != 2'd0) begin
				dec.res[n[0]].out_byte = u2c_pkg::SPACE_BYTE;
				n = n + 2'd1;
			end
			nst = '0;
			if (n != 2'd0) begin
				dec.res[n[0] ^ 1'b1].last_out = 1'b1;
			end
		end
		dec.cnt = n;
	end

endmodule

>>> rtl/core/utf8_to_cp1252_transcoder_core.sv
// utf8_to_cp1252_transcoder_core: top level, input register, decode state and
// a four-entry result queue. Depends on u2c_pkg and u2c_decode.
// Data path: a byte is registered on acceptance, decoded while it is held in the
// input stage and written to the result queue when that stage advances; its first
// result can then be taken. Throughput: one byte per cycle while the result queue
// has room for two results; the single output port moves one result per cycle, so
// bytes giving two results drain at that rate.
// Reset: queue, input stage and decode state clear; language word to 0x00010000.
`timescale 1ns / 1ps

module utf8_to_cp1252_transcoder_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  u2c_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output u2c_pkg::out_t out_data,
	input  logic          cfg_we,
	input  logic [31:0]   cfg_wdata
);

	logic [31:0]   lang_q;
	logic          valid_s1;
	u2c_pkg::in_t  data_s1;
	u2c_pkg::st_t  st_q;
	u2c_pkg::st_t  nst;
	u2c_pkg::dec_t dec;
	logic          pass_thru;
	logic          adv;
	logic          pop;

	u2c_pkg::out_t res_q [u2c_pkg::RES_DEPTH];
	logic [$clog2(u2c_pkg::RES_DEPTH)-1:0] wr_ptr_q, rd_ptr_q, wr_ptr1;
	logic [$clog2(u2c_pkg::RES_DEPTH):0]   cnt_q;

	assign pass_thru = (lang_q & u2c_pkg::LANG_UPPER_MASK) == u2c_pkg::POLISH_SELECT;
	assign adv       = valid_s1 &&
		(cnt_q <= ($clog2(u2c_pkg::RES_DEPTH)+1)'(u2c_pkg::RES_DEPTH - 2));
	assign in_ready  = !valid_s1 || adv;
	assign out_valid = cnt_q != '0;
	assign out_data  = res_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign wr_ptr1   = wr_ptr_q + 1'b1;

	u2c_decode u_decode (
		.in_byte     (data_s1.in_byte),
		.end_of_text (data_s1.end_of_text),
		.pass_thru   (pass_thru),
		.st          (st_q),
		.nst         (nst),
		.dec         (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lang_q <= u2c_pkg::LANG_RESET;
		end else if (cfg_we) begin
			lang_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= nst;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && dec.cnt != 2'd0) begin
			res_q[wr_ptr_q] <= dec.res[0];
		end
		if (adv && dec.cnt == 2'd2) begin
			res_q[wr_ptr1] <= dec.res[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (adv) begin
				wr_ptr_q <= wr_ptr_q + dec.cnt;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (adv ? {1'b0, dec.cnt} : '0) - {2'b0, pop};
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ($clog2(u2c_pkg::RES_DEPTH)+1)'(u2c_pkg::RES_DEPTH))
		else $error("result queue overflow");

	a_pass_one: assert property (@(posedge clk) disable iff (!arst_n)
		adv && pass_thru |-> dec.cnt == 2'd1 && dec.res[0].out_byte == data_s1.in_byte)
		else $error("pass-through must give the raw byte once");

	a_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv && data_s1.end_of_text |=> st_q == '0)
		else $error("decode state not cleared at end of text");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(data_s1))
		else $error("input stage lost a stalled transaction");

endmodule
